// File: rtl/tkde_pkg.sv
// Shared types, constants and the sequencer program of the touch keypad digit entry block.
package tkde_pkg;

  // Field widths.
  localparam int COORD_W = 10;
  localparam int PRESS_W = 12;
  localparam int BORDER_W = 6;
  localparam int SIZE_W = 10;
  localparam int KIND_W = 3;
  localparam int DIGIT_W = 4;
  localparam int POS_W = 6;

  // Key grid. Bounds need 13 bits: 3 * (1023 + 63) + 63 + 1023 < 8192.
  localparam int KEY_COLUMNS = 3;
  localparam int KEY_ROWS = 4;
  localparam int KEY_W = 4;
  localparam int BND_W = 13;
  localparam int PITCH_W = 11;
  localparam logic [KEY_W-1:0] KEY_OK = 4'd9;
  localparam logic [KEY_W-1:0] KEY_CANCEL = 4'd11;

  // Configuration registers.
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [1:0] REG_BORDER = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [BORDER_W-1:0] BORDER_RESET = 6'd12;
  localparam logic [SIZE_W-1:0] WIDTH_RESET = 10'd64;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 10'd65;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_TYPED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_OK_REPLAY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL_REPLAY = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCELLED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY_OK = 3'd4;

  // Program steps.
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] S_CHECK = 4'd1;
  localparam logic [STEP_W-1:0] S_SETTLE = 4'd2;
  localparam logic [STEP_W-1:0] S_HIT = 4'd3;
  localparam logic [STEP_W-1:0] S_DISPATCH = 4'd4;
  localparam logic [STEP_W-1:0] S_EMPTY = 4'd5;
  localparam logic [STEP_W-1:0] S_CANCEL = 4'd6;
  localparam logic [STEP_W-1:0] S_TYPE = 4'd7;
  localparam logic [STEP_W-1:0] S_PRIME = 4'd8;
  localparam logic [STEP_W-1:0] S_REPLAY = 4'd9;

  // Datapath operations.
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_TAKE = 3'd0;
  localparam logic [OP_W-1:0] OP_CHECK = 3'd1;
  localparam logic [OP_W-1:0] OP_NOP = 3'd2;
  localparam logic [OP_W-1:0] OP_HIT = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPATCH = 3'd4;
  localparam logic [OP_W-1:0] OP_FIXED = 3'd5;
  localparam logic [OP_W-1:0] OP_TYPE = 3'd6;
  localparam logic [OP_W-1:0] OP_REPLAY = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [KIND_W-1:0] kind;
    logic [STEP_W-1:0] next;
  } ucode_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } key_hit_t;

  // The control store: one word per step.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    unique case (step)
      S_IDLE:     w = '{op: OP_TAKE,     kind: KIND_TYPED,     next: S_CHECK};
      S_CHECK:    w = '{op: OP_CHECK,    kind: KIND_TYPED,     next: S_SETTLE};
      S_SETTLE:   w = '{op: OP_NOP,      kind: KIND_TYPED,     next: S_HIT};
      S_HIT:      w = '{op: OP_HIT,      kind: KIND_TYPED,     next: S_DISPATCH};
      S_DISPATCH: w = '{op: OP_DISPATCH, kind: KIND_TYPED,     next: S_IDLE};
      S_EMPTY:    w = '{op: OP_FIXED,    kind: KIND_EMPTY_OK,  next: S_IDLE};
      S_CANCEL:   w = '{op: OP_FIXED,    kind: KIND_CANCELLED, next: S_IDLE};
      S_TYPE:     w = '{op: OP_TYPE,     kind: KIND_TYPED,     next: S_IDLE};
      S_PRIME:    w = '{op: OP_NOP,      kind: KIND_TYPED,     next: S_REPLAY};
      S_REPLAY:   w = '{op: OP_REPLAY,   kind: KIND_TYPED,     next: S_IDLE};
      default:    w = '{op: OP_NOP,      kind: KIND_TYPED,     next: S_IDLE};
    endcase
    return w;
  endfunction

  // Keys 0..8 are digits 1..9; key 10 is digit 0.
  function automatic logic [DIGIT_W-1:0] key_digit(input logic [KEY_W-1:0] key);
    logic [DIGIT_W-1:0] d;
    if (key < 4'd9) begin
      d = key + 4'd1;
    end else begin
      d = '0;
    end
    return d;
  endfunction

endpackage

// File: rtl/tkde_touch_if.sv
// Channel that carries one touch-panel sample.
interface tkde_touch_if import tkde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] touch_x;
  logic [COORD_W-1:0] touch_y;
  logic [PRESS_W-1:0] touch_pressure;

  modport source(output valid, touch_x, touch_y, touch_pressure, input ready);
  modport sink(input valid, touch_x, touch_y, touch_pressure, output ready);
endinterface

// File: rtl/tkde_result_if.sv
// Channel that carries one digit entry result.
interface tkde_result_if import tkde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [DIGIT_W-1:0] digit_value;
  logic [POS_W-1:0]   digit_position;
  logic               last_of_run;

  modport source(output valid, event_kind, digit_value, digit_position, last_of_run,
                 input ready);
  modport sink(input valid, event_kind, digit_value, digit_position, last_of_run,
               output ready);
endinterface

// File: rtl/tkde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 50,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/tkde_locator.sv
// Key grid hit test: registered key bounds and the compare against a sample.
module tkde_locator import tkde_pkg::*; (
  input  logic                clk,
  input  logic [BORDER_W-1:0] key_border,
  input  logic [SIZE_W-1:0]   key_width,
  input  logic [SIZE_W-1:0]   key_height,
  input  logic [COORD_W-1:0]  touch_x,
  input  logic [COORD_W-1:0]  touch_y,
  output key_hit_t            found
);

  logic [PITCH_W-1:0] pitch_x;
  logic [PITCH_W-1:0] pitch_y;
  logic [BND_W-1:0]   col_lo [KEY_COLUMNS];
  logic [BND_W-1:0]   col_hi [KEY_COLUMNS];
  logic [BND_W-1:0]   row_lo [KEY_ROWS];
  logic [BND_W-1:0]   row_hi [KEY_ROWS];
  logic [KEY_COLUMNS-1:0] col_hit;
  logic [KEY_ROWS-1:0]    row_hit;
  logic [1:0]         col_sel;
  logic [1:0]         row_sel;
  logic [BND_W-1:0]   x_ext;
  logic [BND_W-1:0]   y_ext;

  // The bounds follow the registers through the pitch, low-bound and high-bound
  // registers. Registers are to change only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    pitch_x <= PITCH_W'(key_width) + PITCH_W'(key_border);
    pitch_y <= PITCH_W'(key_height) + PITCH_W'(key_border);
    for (int c = 0; c < KEY_COLUMNS; c++) begin
      col_lo[c] <= BND_W'(key_border) + BND_W'(c) * BND_W'(pitch_x);
      col_hi[c] <= col_lo[c] + BND_W'(key_width);
    end
    for (int r = 0; r < KEY_ROWS; r++) begin
      row_lo[r] <= BND_W'(key_border) + BND_W'(r) * BND_W'(pitch_y);
      row_hi[r] <= row_lo[r] + BND_W'(key_height);
    end
  end

  always_comb begin
    x_ext = BND_W'(touch_x);
    y_ext = BND_W'(touch_y);
    for (int c = 0; c < KEY_COLUMNS; c++) begin
      col_hit[c] = (col_lo[c] < x_ext) && (x_ext < col_hi[c]);
    end
    for (int r = 0; r < KEY_ROWS; r++) begin
      row_hit[r] = (row_lo[r] < y_ext) && (y_ext < row_hi[r]);
    end
    // The lowest-numbered key wins: lowest hit row, then lowest hit column.
    col_sel = '0;
    for (int c = KEY_COLUMNS - 1; c >= 0; c--) begin
      if (col_hit[c]) begin
        col_sel = 2'(c);
      end
    end
    row_sel = '0;
    for (int r = KEY_ROWS - 1; r >= 0; r--) begin
      if (row_hit[r]) begin
        row_sel = 2'(r);
      end
    end
    found.hit = (|col_hit) && (|row_hit);
    found.key = KEY_W'(row_sel * KEY_COLUMNS) + KEY_W'(col_sel);
  end

endmodule

// File: rtl/touch_keypad_digit_entry.sv
// Top level of the touch keypad digit entry block: register port and sequencer.
//
//   Channel   Direction   Payload
//   touch     in          touch_x, touch_y, touch_pressure
//   result    out         event_kind, digit_value, digit_position, last_of_run
//   APB       in/out      key_border (0x0), key_width (0x4), key_height (0x8)
//
// One sample is taken at a time. A zero-pressure sample or one of a press
// already handled ends at the check, and a touch outside every key at the
// dispatch. A typed digit, cancel or empty OK gives one result, and an OK
// replay of n digits gives n results. A full buffer gives the echo and then
// ENTRY_DEPTH replays from the digit RAM read port at one digit a cycle while the result is not stalled.
// Reset clears the sequencer, count, press latch and registers; the digit RAM
// is not cleared. A stalled result holds its step until the transfer.
module touch_keypad_digit_entry import tkde_pkg::*; #(
  parameter int ENTRY_DEPTH = 50
) (
  input  logic                  clk,
  input  logic                  rst,
  tkde_touch_if.sink            touch,
  tkde_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int CNT_W = $clog2(ENTRY_DEPTH + 1);

  logic [BORDER_W-1:0] key_border;
  logic [SIZE_W-1:0]   key_width;
  logic [SIZE_W-1:0]   key_height;
  logic                cfg_write;

  logic [STEP_W-1:0]   step, step_next;
  logic [COORD_W-1:0]  sample_x;
  logic [COORD_W-1:0]  sample_y;
  logic [PRESS_W-1:0]  sample_pressure;
  logic                press_handled, press_handled_next;
  logic [CNT_W-1:0]    entry_count, entry_count_next;
  key_hit_t            key_found;
  key_hit_t            key_reg, key_reg_next;
  logic [IDX_W-1:0]    idx, idx_next;
  logic [CNT_W-1:0]    run_len, run_len_next;
  logic [KIND_W-1:0]   run_kind, run_kind_next;
  logic                out_valid, out_valid_next;
  logic [KIND_W-1:0]   out_kind, out_kind_next;
  logic [DIGIT_W-1:0]  out_digit, out_digit_next;
  logic [POS_W-1:0]    out_pos, out_pos_next;
  logic                out_last, out_last_next;

  ucode_t              uc;
  logic                out_free;
  logic                take;
  logic [CNT_W-1:0]    count_inc;
  logic                buffer_full;
  logic                run_end;
  logic                wr_en;
  logic [DIGIT_W-1:0]  typed_digit;
  logic [DIGIT_W-1:0]  rd_data;

  // Register port.
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_border <= BORDER_RESET;
      key_width  <= WIDTH_RESET;
      key_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_BORDER: key_border <= pwdata[BORDER_W-1:0];
        REG_WIDTH:  key_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: key_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_BORDER: prdata = CFG_DATA_W'(key_border);
      REG_WIDTH:  prdata = CFG_DATA_W'(key_width);
      REG_HEIGHT: prdata = CFG_DATA_W'(key_height);
      default:    prdata = '0;
    endcase
  end

  tkde_locator u_locator (
    .clk        (clk),
    .key_border (key_border),
    .key_width  (key_width),
    .key_height (key_height),
    .touch_x    (sample_x),
    .touch_y    (sample_y),
    .found      (key_found)
  );

  tkde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (ENTRY_DEPTH)
  ) u_digits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (typed_digit),
    .rd_addr (idx_next),
    .rd_data (rd_data)
  );

  // Sequencer: the control word of the current step drives the datapath.
  always_comb begin
    uc = ucode_rom(step);
    out_free = !out_valid || result.ready;
    take = (uc.op == OP_TAKE);
    count_inc = entry_count + 1'b1;
    buffer_full = (count_inc == CNT_W'(ENTRY_DEPTH));
    run_end = ((CNT_W'(idx) + 1'b1) == run_len);
    typed_digit = key_digit(key_reg.key);

    step_next = step;
    press_handled_next = press_handled;
    entry_count_next = entry_count;
    key_reg_next = key_reg;
    idx_next = idx;
    run_len_next = run_len;
    run_kind_next = run_kind;
    out_valid_next = out_valid && !result.ready;
    out_kind_next = out_kind;
    out_digit_next = out_digit;
    out_pos_next = out_pos;
    out_last_next = out_last;
    wr_en = 1'b0;

    unique case (uc.op)
      OP_TAKE: begin
        if (touch.valid) begin
          step_next = uc.next;
        end
      end
      OP_CHECK: begin
        if (sample_pressure == '0) begin
          press_handled_next = 1'b0;
          step_next = S_IDLE;
        end else if (press_handled) begin
          step_next = S_IDLE;
        end else begin
          press_handled_next = 1'b1;
          step_next = uc.next;
        end
      end
      OP_NOP: begin
        step_next = uc.next;
      end
      OP_HIT: begin
        key_reg_next = key_found;
        step_next = uc.next;
      end
      OP_DISPATCH: begin
        priority if (!key_reg.hit) begin
          step_next = uc.next;
        end else if (key_reg.key == KEY_OK) begin
          if (entry_count == '0) begin
            step_next = S_EMPTY;
          end else begin
            run_len_next = entry_count;
            run_kind_next = KIND_OK_REPLAY;
            idx_next = '0;
            step_next = S_PRIME;
          end
        end else if (key_reg.key == KEY_CANCEL) begin
          step_next = S_CANCEL;
        end else begin
          step_next = S_TYPE;
        end
      end
      OP_FIXED: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next = uc.kind;
          out_digit_next = '0;
          out_pos_next = '0;
          out_last_next = 1'b1;
          entry_count_next = '0;
          step_next = uc.next;
        end
      end
      OP_TYPE: begin
        if (out_free) begin
          wr_en = 1'b1;
          out_valid_next = 1'b1;
          out_kind_next = KIND_TYPED;
          out_digit_next = typed_digit;
          out_pos_next = POS_W'(entry_count);
          out_last_next = !buffer_full;
          if (buffer_full) begin
            entry_count_next = '0;
            run_len_next = CNT_W'(ENTRY_DEPTH);
            run_kind_next = KIND_FULL_REPLAY;
            idx_next = '0;
            step_next = S_PRIME;
          end else begin
            entry_count_next = count_inc;
            step_next = uc.next;
          end
        end
      end
      OP_REPLAY: begin
        // The RAM reads at idx_next, so rd_data always holds entry idx.
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next = run_kind;
          out_digit_next = rd_data;
          out_pos_next = POS_W'(idx);
          out_last_next = run_end;
          if (run_end) begin
            entry_count_next = '0;
            step_next = uc.next;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        step_next = S_IDLE;
      end
    endcase
  end

  assign touch.ready = take;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
      press_handled <= 1'b0;
      entry_count <= '0;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      press_handled <= press_handled_next;
      entry_count <= entry_count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take && touch.valid) begin
      sample_x <= touch.touch_x;
      sample_y <= touch.touch_y;
      sample_pressure <= touch.touch_pressure;
    end
    key_reg <= key_reg_next;
    idx <= idx_next;
    run_len <= run_len_next;
    run_kind <= run_kind_next;
    out_kind <= out_kind_next;
    out_digit <= out_digit_next;
    out_pos <= out_pos_next;
    out_last <= out_last_next;
  end

  assign result.valid = out_valid;
  assign result.event_kind = out_kind;
  assign result.digit_value = out_digit;
  assign result.digit_position = out_pos;
  assign result.last_of_run = out_last;

endmodule
